[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the glyph mapper.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AST_ALWAYS(name, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`define AST_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define AST_ALWAYS(name, cond)
`define AST_IMPLY(name, ante, cons)
`endif
`endif

[rtl/tbgm_pkg.sv]
// Shared types, constants and helper functions of the tile brightness glyph mapper.
// Has no dependencies; tbgm_front, tbgm_queue, tbgm_back and the top level import it.
`timescale 1ns / 1ps
`default_nettype none
package tbgm_pkg;

  localparam int MAX_WIDTH     = 4096;
  localparam int TABLE_ENTRIES = 16;
  localparam int MAX_TILE      = 64;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [15:0] LFSR_MASK  = 16'hB400;
  localparam logic [15:0] SEED_RESET = 16'd44257;

  typedef enum logic [2:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_TILE_WIDTH   = 3'd2,
    CFG_TILE_HEIGHT  = 3'd3,
    CFG_RANDOM_SEED  = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_TABLE = 1'b1
  } req_kind_t;

  typedef enum logic {F_IDLE, F_ADD} front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_DIV, B_MATCH, B_MOD, B_PICK, B_OUT
  } back_state_t;

  // Effective geometry after clamping.
  typedef struct packed {
    logic [12:0] fw;
    logic [12:0] fh;
    logic [6:0]  tw;
    logic [6:0]  th;
  } geom_t;

  // One queue entry: either a finished tile sum or a table write.
  typedef struct packed {
    req_kind_t   kind;
    logic [19:0] sum;
    logic [12:0] area;
    logic [11:0] tc;
    logic [11:0] trow;
    logic        eol;
    logic        eof;
    logic [3:0]  idx;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [7:0]  gl;
    logic        vld;
  } q_item_t;

  function automatic logic [12:0] clamp_frame(input logic [12:0] v);
    if (v == 13'd0) return 13'd1;
    if (v > 13'(MAX_WIDTH)) return 13'(MAX_WIDTH);
    return v;
  endfunction

  function automatic logic [6:0] clamp_tile(input logic [6:0] v);
    if (v == 7'd0) return 7'd1;
    if (v > 7'(MAX_TILE)) return 7'(MAX_TILE);
    return v;
  endfunction

  function automatic logic [15:0] lfsr_step(input logic [15:0] s);
    return {1'b0, s[15:1]} ^ (s[0] ? LFSR_MASK : 16'd0);
  endfunction

endpackage
`default_nettype wire

[rtl/tbgm_ram.sv]
// Generic single-port-write, registered-read RAM.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module tbgm_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

[rtl/tbgm_front.sv]
// Front end: accepts items, tracks raster position, accumulates column sums.
// Depends on tbgm_pkg and tbgm_ram; pushes tile and table items into the queue.
`timescale 1ns / 1ps
`default_nettype none
module tbgm_front import tbgm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire geom_t       geom,
  input  wire logic        restart,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire req_kind_t   in_kind,
  input  wire logic [7:0]  in_pix,
  input  wire logic [3:0]  in_idx,
  input  wire logic [7:0]  in_lo,
  input  wire logic [7:0]  in_hi,
  input  wire logic [7:0]  in_gl,
  input  wire logic        in_vld,
  input  wire logic        q_full,
  output logic             q_push,
  output q_item_t          q_data
);
  front_state_t fst_r, fst_nxt;
  logic [11:0] col_r, tc_r, row_r, trow_r, band_r;
  logic [5:0]  in_tile_r, rib_r;
  logic [12:0] col_base_r;
  logic [7:0]  pix_r;
  logic        take, first, last_col, last_row, row_end;
  logic [19:0] rdata, sum;
  logic [12:0] wdiff, hdiff;
  logic [6:0]  w, h;
  logic [13:0] area;

  assign take = in_valid && in_ready;

  always_comb begin
    fst_nxt = fst_r;
    unique case (fst_r)
      F_IDLE: if (take && in_kind == REQ_PIXEL) fst_nxt = F_ADD;
      F_ADD:  fst_nxt = F_IDLE;
      default: fst_nxt = F_IDLE;
    endcase
  end

  tbgm_ram #(.WIDTH(20), .DEPTH(MAX_WIDTH)) u_sums (
    .clk  (clk),
    .we   (fst_r == F_ADD),
    .waddr(tc_r),
    .wdata(sum),
    .raddr(tc_r),
    .rdata(rdata)
  );

  assign first    = (rib_r == 6'd0) && (in_tile_r == 6'd0);
  assign sum      = first ? {12'd0, pix_r} : rdata + {12'd0, pix_r};
  assign row_end  = {1'b0, col_r} == geom.fw - 13'd1;
  assign last_col = (in_tile_r == 6'(geom.tw - 7'd1)) || row_end;
  assign last_row = (rib_r == 6'(geom.th - 7'd1)) || ({1'b0, row_r} == geom.fh - 13'd1);
  assign wdiff    = geom.fw - col_base_r;
  assign hdiff    = geom.fh - {1'b0, band_r};
  assign w        = (wdiff > {6'd0, geom.tw}) ? geom.tw : wdiff[6:0];
  assign h        = (hdiff > {6'd0, geom.th}) ? geom.th : hdiff[6:0];
  assign area     = w * h;

  always_comb begin
    in_ready = (fst_r == F_IDLE) && !q_full;
    q_push   = 1'b0;
    q_data   = '0;
    q_data.kind = in_kind;
    q_data.idx  = in_idx;
    q_data.lo   = in_lo;
    q_data.hi   = in_hi;
    q_data.gl   = in_gl;
    q_data.vld  = in_vld;
    unique case (fst_r)
      F_IDLE: q_push = take && in_kind == REQ_TABLE;
      F_ADD: begin
        q_push      = last_col && last_row;
        q_data      = '0;
        q_data.kind = REQ_PIXEL;
        q_data.sum  = sum;
        q_data.area = area[12:0];
        q_data.tc   = tc_r;
        q_data.trow = trow_r;
        q_data.eol  = row_end;
        q_data.eof  = row_end && ({1'b0, row_r} == geom.fh - 13'd1);
      end
      default: q_push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fst_r == F_IDLE && take) begin
      pix_r <= in_pix;
    end
    if (!rst_n) begin
      fst_r      <= F_IDLE;
      col_r      <= '0;
      tc_r       <= '0;
      row_r      <= '0;
      trow_r     <= '0;
      band_r     <= '0;
      in_tile_r  <= '0;
      rib_r      <= '0;
      col_base_r <= '0;
    end else if (restart) begin
      fst_r      <= F_IDLE;
      col_r      <= '0;
      tc_r       <= '0;
      row_r      <= '0;
      trow_r     <= '0;
      band_r     <= '0;
      in_tile_r  <= '0;
      rib_r      <= '0;
      col_base_r <= '0;
    end else begin
      fst_r <= fst_nxt;
      if (fst_r == F_ADD) begin
        if (row_end) begin
          col_r      <= '0;
          tc_r       <= '0;
          in_tile_r  <= '0;
          col_base_r <= '0;
          if ({1'b0, row_r} == geom.fh - 13'd1) begin
            row_r  <= '0;
            rib_r  <= '0;
            trow_r <= '0;
            band_r <= '0;
          end else begin
            row_r <= row_r + 12'd1;
            if (rib_r == 6'(geom.th - 7'd1)) begin
              rib_r  <= '0;
              trow_r <= trow_r + 12'd1;
              band_r <= band_r + 12'(geom.th);
            end else begin
              rib_r <= rib_r + 6'd1;
            end
          end
        end else begin
          col_r <= col_r + 12'd1;
          if (in_tile_r == 6'(geom.tw - 7'd1)) begin
            in_tile_r  <= '0;
            tc_r       <= tc_r + 12'd1;
            col_base_r <= col_base_r + 13'(geom.tw);
          end else begin
            in_tile_r <= in_tile_r + 6'd1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

[rtl/tbgm_queue.sv]
// Short FIFO between the front and back ends.
// Depends on tbgm_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none
module tbgm_queue import tbgm_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire q_item_t wdata,
  input  wire logic    pop,
  output q_item_t      rdata,
  output logic         full,
  output logic         empty
);
  localparam int AW = $clog2(QUEUE_DEPTH);

  q_item_t        ent_r [QUEUE_DEPTH];
  logic [AW-1:0]  wp_r, rp_r;
  logic [AW:0]    cnt_r;

  assign full  = cnt_r == (AW+1)'(QUEUE_DEPTH);
  assign empty = cnt_r == '0;
  assign rdata = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= wdata;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + AW'(1);
      if (pop)  rp_r <= rp_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

[rtl/tbgm_back.sv]
// Back end: applies table writes, divides tile sums, matches the range table and picks a glyph.
// Depends on tbgm_pkg; reads items from tbgm_queue and drives the result register.
`timescale 1ns / 1ps
`default_nettype none
module tbgm_back import tbgm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        seed_load,
  input  wire logic [15:0] seed,
  input  wire logic        q_empty,
  input  wire q_item_t     q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_glyph,
  output logic             out_fallback,
  output logic [7:0]       out_mean,
  output logic [11:0]      out_tc,
  output logic [11:0]      out_trow,
  output logic             out_eol,
  output logic             out_eof
);
  localparam int TW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  back_state_t bst_r, bst_nxt;
  logic              tv_r [TABLE_ENTRIES];
  logic [7:0]        tlo_r [TABLE_ENTRIES];
  logic [7:0]        thi_r [TABLE_ENTRIES];
  logic [7:0]        tgl_r [TABLE_ENTRIES];
  logic [19:0]       rem_r;
  logic [12:0]       area_r;
  logic [7:0]        quo_r, glyph_r;
  logic [2:0]        k_r;
  logic [15:0]       lfsr_r;
  logic [TABLE_ENTRIES-1:0] match, match_r;
  logic [CW-1:0]     cnt, cnt_r, mrem_r, pick_r;
  logic [CW:0]       mtry;
  logic [3:0]        bit_r;
  logic [TW-1:0]     idx_r;
  logic [11:0]       tc_r, trow_r;
  logic              eol_r, eof_r, fb_r;
  logic [20:0]       dshift;

  assign dshift = {8'd0, area_r} << k_r;
  assign mtry   = {mrem_r, lfsr_r[bit_r]};

  always_comb begin
    cnt = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      match[i] = tv_r[i] && (tlo_r[i] <= quo_r) && (quo_r <= thi_r[i]);
      cnt      = cnt + CW'(match[i]);
    end
  end

  always_comb begin
    bst_nxt = bst_r;
    unique case (bst_r)
      B_IDLE:  if (!q_empty && q_data.kind == REQ_PIXEL) bst_nxt = B_DIV;
      B_DIV:   if (k_r == 3'd0) bst_nxt = B_MATCH;
      B_MATCH: bst_nxt = (cnt == '0) ? B_OUT : B_MOD;
      B_MOD:   if (bit_r == 4'd0) bst_nxt = B_PICK;
      B_PICK:  if (match_r[idx_r] && pick_r == '0) bst_nxt = B_OUT;
      B_OUT:   if (out_ready) bst_nxt = B_IDLE;
      default: bst_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    out_valid = 1'b0;
    unique case (bst_r)
      B_IDLE:  q_pop = !q_empty;
      B_OUT:   out_valid = 1'b1;
      default: q_pop = 1'b0;
    endcase
  end

  assign out_glyph    = glyph_r;
  assign out_fallback = fb_r;
  assign out_mean     = quo_r;
  assign out_tc       = tc_r;
  assign out_trow     = trow_r;
  assign out_eol      = eol_r;
  assign out_eof      = eof_r;

  always_ff @(posedge clk) begin
    unique case (bst_r)
      B_IDLE: begin
        if (!q_empty && q_data.kind == REQ_TABLE &&
            {1'b0, q_data.idx} < 5'(TABLE_ENTRIES)) begin
          tlo_r[TW'(q_data.idx)] <= q_data.lo;
          thi_r[TW'(q_data.idx)] <= q_data.hi;
          tgl_r[TW'(q_data.idx)] <= q_data.gl;
        end
        rem_r  <= q_data.sum;
        area_r <= q_data.area;
        tc_r   <= q_data.tc;
        trow_r <= q_data.trow;
        eol_r  <= q_data.eol;
        eof_r  <= q_data.eof;
        quo_r  <= '0;
        k_r    <= 3'd7;
      end
      B_DIV: begin
        // Restoring division; the mean never exceeds 255, so 8 steps suffice.
        if ({1'b0, rem_r} >= dshift) begin
          rem_r       <= rem_r - dshift[19:0];
          quo_r[k_r]  <= 1'b1;
        end
        k_r <= k_r - 3'd1;
      end
      B_MATCH: begin
        match_r <= match;
        cnt_r   <= cnt;
        mrem_r  <= '0;
        bit_r   <= 4'd15;
        idx_r   <= '0;
        fb_r    <= cnt == '0;
        glyph_r <= '0;
      end
      B_MOD: begin
        // One bit of the LFSR value per cycle, remainder by the match count.
        mrem_r <= (mtry >= {1'b0, cnt_r}) ? CW'(mtry - {1'b0, cnt_r}) : CW'(mtry);
        bit_r  <= bit_r - 4'd1;
        if (bit_r == 4'd0) begin
          pick_r <= (mtry >= {1'b0, cnt_r}) ? CW'(mtry - {1'b0, cnt_r}) : CW'(mtry);
        end
      end
      B_PICK: begin
        if (match_r[idx_r]) begin
          if (pick_r == '0) glyph_r <= tgl_r[idx_r];
          else pick_r <= pick_r - CW'(1);
        end
        idx_r <= idx_r + TW'(1);
      end
      default: ;
    endcase

    if (!rst_n) begin
      bst_r  <= B_IDLE;
      lfsr_r <= SEED_RESET;
      for (int i = 0; i < TABLE_ENTRIES; i++) tv_r[i] <= 1'b0;
    end else begin
      bst_r <= bst_nxt;
      if (seed_load) begin
        lfsr_r <= seed;
      end else if (bst_r == B_MATCH) begin
        lfsr_r <= lfsr_step(lfsr_r);
      end
      if (bst_r == B_IDLE && !q_empty && q_data.kind == REQ_TABLE &&
          {1'b0, q_data.idx} < 5'(TABLE_ENTRIES)) begin
        tv_r[TW'(q_data.idx)] <= q_data.vld;
      end
    end
  end
endmodule
`default_nettype wire

[rtl/tile_brightness_glyph_mapper_core.sv]
// Tile brightness glyph mapper, top level: configuration registers and wiring.
// Depends on tbgm_pkg, tbgm_front, tbgm_queue, tbgm_back and assert_macros.svh.
//
// Usage: pixels (in_tuser = 0) arrive in raster order on the in_ stream; an item
// with in_tuser = 1 writes one slot of the 16-entry brightness range table.
// When the last pixel of a tile arrives, one result leaves on the out_ stream
// with the chosen glyph, the floor mean and the tile position; out_tlast marks
// the last tile of a tile row.
// Flow: a pixel passes the front-end states F_IDLE (column-sum RAM read) and
// F_ADD (add and write back); a table write is taken in F_IDLE alone. The back
// end handles a tile with no matching slot by queue pop, 8 division steps, the
// match step and the output transfer; a tile with matches adds 16 remainder
// steps and 1 to 16 table scan steps before the output transfer.
// A 4-entry queue parts the two ends; while the receiver stalls, the held
// result blocks the back end and the front end keeps taking items until the
// queue fills. Reset restores the default geometry and seed, marks all table
// slots invalid and restarts the frame. Geometry writes restart the frame.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tile_brightness_glyph_mapper_core import tbgm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [7:0] pixel_value, [11:8] entry_index, [19:12] range_low,
  // [27:20] range_high, [35:28] entry_glyph, [36] entry_valid, rest zero
  input  wire logic [39:0] in_tdata,
  // [0] req_type
  input  wire logic        in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] glyph_code, [15:8] average_level, [27:16] tile_column,
  // [39:28] tile_row
  output logic [39:0]      out_tdata,
  // [0] is_fallback, [1] end_of_frame
  output logic [1:0]       out_tuser,
  // end_of_line
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  logic [12:0] fw_r, fh_r;
  logic [6:0]  tw_r, th_r;
  logic        cfg_take, restart, seed_load;
  geom_t       geom;
  q_item_t     push_data, pop_data;
  logic        q_push, q_pop, q_full, q_empty;
  logic [7:0]  glyph, mean;
  logic [11:0] tc, trow;
  logic        fb, eol, eof;

  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid && cfg_ready;

  always_comb begin
    restart   = 1'b0;
    seed_load = 1'b0;
    if (cfg_take) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT,
        CFG_TILE_WIDTH, CFG_TILE_HEIGHT: restart = 1'b1;
        CFG_RANDOM_SEED:                 seed_load = 1'b1;
        default:                         restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r   <= 13'd640;
      fh_r   <= 13'd480;
      tw_r   <= 7'd5;
      th_r   <= 7'd5;
    end else if (cfg_take) begin
      case (cfg_reg_t'(cfg_index))
        CFG_FRAME_WIDTH:  fw_r   <= cfg_data[12:0];
        CFG_FRAME_HEIGHT: fh_r   <= cfg_data[12:0];
        CFG_TILE_WIDTH:   tw_r   <= cfg_data[6:0];
        CFG_TILE_HEIGHT:  th_r   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign geom.fw = clamp_frame(fw_r);
  assign geom.fh = clamp_frame(fh_r);
  assign geom.tw = clamp_tile(tw_r);
  assign geom.th = clamp_tile(th_r);

  tbgm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .geom    (geom),
    .restart (restart),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .in_kind (req_kind_t'(in_tuser)),
    .in_pix  (in_tdata[7:0]),
    .in_idx  (in_tdata[11:8]),
    .in_lo   (in_tdata[19:12]),
    .in_hi   (in_tdata[27:20]),
    .in_gl   (in_tdata[35:28]),
    .in_vld  (in_tdata[36]),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (push_data)
  );

  tbgm_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(push_data),
    .pop  (q_pop),
    .rdata(pop_data),
    .full (q_full),
    .empty(q_empty)
  );

  tbgm_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .seed_load   (seed_load),
    .seed        (cfg_data),
    .q_empty     (q_empty),
    .q_data      (pop_data),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_glyph   (glyph),
    .out_fallback(fb),
    .out_mean    (mean),
    .out_tc      (tc),
    .out_trow    (trow),
    .out_eol     (eol),
    .out_eof     (eof)
  );

  assign out_tdata = {trow, tc, mean, glyph};
  assign out_tuser = {eof, fb};
  assign out_tlast = eol;

  `AST_IMPLY(a_eof_ends_line, out_tvalid && out_tuser[1], out_tlast)
  `AST_IMPLY(a_fallback_zero_glyph, out_tvalid && out_tuser[0], out_tdata[7:0] == 8'd0)
  `AST_ALWAYS(a_queue_not_over, !(q_push && q_full))
endmodule
`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for tile_brightness_glyph_mapper_core.
// Depends on tbgm_pkg and the core RTL. A built-in tile predictor computes the expected
// results; pixel and table transfers are driven with random bursts and output stalls.
`timescale 1ns / 1ps
module testbench;
  import tbgm_pkg::*;

  typedef struct {
    logic [7:0]  glyph;
    logic        fb;
    logic [7:0]  avg;
    logic [11:0] col;
    logic [11:0] row;
    logic        eol;
    logic        eof;
  } tile_res_t;

  typedef struct {
    bit       tbl;
    bit [7:0] pix;
    bit [3:0] idx;
    bit [7:0] lo;
    bit [7:0] hi;
    bit [7:0] gl;
    bit       v;
    bit       typed;
    bit [7:0] e_gl;
    bit       e_fb;
    bit [7:0] e_avg;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  tile_brightness_glyph_mapper_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state.
  logic [12:0] geo_fw, geo_fh;
  logic [6:0]  geo_tw, geo_th;
  logic [15:0] sel_lfsr;
  int unsigned cur_col, cur_row, cur_band;
  int unsigned col_sum [MAX_WIDTH];
  logic        slot_on [TABLE_ENTRIES];
  logic [7:0]  slot_lo [TABLE_ENTRIES];
  logic [7:0]  slot_hi [TABLE_ENTRIES];
  logic [7:0]  slot_gl [TABLE_ENTRIES];

  tile_res_t   tile_expect [$];
  int          errors = 0;
  int          items_sent = 0;
  int          burst_left = 0;

  function automatic int unsigned bounded(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic void restart_geometry();
    cur_col = 0;
    cur_row = 0;
    cur_band = 0;
  endfunction

  // Advances the raster position by one pixel; returns 1 when a tile completes.
  function automatic bit tile_from_pixel(input logic [7:0] pix, output tile_res_t r);
    int unsigned fw, fh, tw, th, tc, sub, w, h, mean, hits, pick;
    bit done;
    fw = bounded(geo_fw, MAX_WIDTH);
    fh = bounded(geo_fh, MAX_WIDTH);
    tw = bounded(geo_tw, MAX_TILE);
    th = bounded(geo_th, MAX_TILE);
    tc = cur_col / tw;
    sub = cur_col % tw;
    if (cur_band == 0 && sub == 0) col_sum[tc] = pix;
    else col_sum[tc] += pix;
    done = ((sub == tw - 1) || (cur_col == fw - 1)) &&
           ((cur_band == th - 1) || (cur_row == fh - 1));
    r = '{default: '0};
    if (done) begin
      w = fw - tc * tw;
      if (w > tw) w = tw;
      h = fh - (cur_row - cur_band);
      if (h > th) h = th;
      mean = col_sum[tc] / (w * h);
      if (mean > 255) mean = 255;
      sel_lfsr = (sel_lfsr >> 1) ^ (sel_lfsr[0] ? 16'hB400 : 16'h0000);
      hits = 0;
      for (int i = 0; i < TABLE_ENTRIES; i++)
        if (slot_on[i] && slot_lo[i] <= mean && mean <= slot_hi[i]) hits++;
      if (hits > 0) begin
        pick = sel_lfsr % hits;
        for (int i = 0; i < TABLE_ENTRIES; i++)
          if (slot_on[i] && slot_lo[i] <= mean && mean <= slot_hi[i]) begin
            if (pick == 0) begin
              r.glyph = slot_gl[i];
              break;
            end
            pick--;
          end
      end
      r.fb = (hits == 0);
      r.avg = mean[7:0];
      r.col = tc[11:0];
      r.row = 12'(cur_row / th);
      r.eol = (cur_col == fw - 1);
      r.eof = r.eol && (cur_row == fh - 1);
    end
    cur_col++;
    if (cur_col >= fw) begin
      cur_col = 0;
      cur_row++;
      cur_band++;
      if (cur_band >= th) cur_band = 0;
      if (cur_row >= fh) begin
        cur_row = 0;
        cur_band = 0;
      end
    end
    return done;
  endfunction

  // Drives one item; the sender idles for a random gap, sometimes none, between bursts of random length.
  task automatic send_item(input bit tbl, input logic [7:0] pix, input logic [3:0] idx,
                           input logic [7:0] lo, input logic [7:0] hi, input logic [7:0] gl,
                           input bit v, input bit typed, input tile_res_t typed_res);
    tile_res_t r;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_tvalid = 1'b1;
    in_tuser = tbl ? REQ_TABLE : REQ_PIXEL;
    in_tdata = {3'b000, v, gl, hi, lo, idx, pix};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (tbl) begin
      slot_on[idx] = v;
      slot_lo[idx] = lo;
      slot_hi[idx] = hi;
      slot_gl[idx] = gl;
    end else if (tile_from_pixel(pix, r)) begin
      tile_expect = {tile_expect, (typed ? typed_res : r)};
    end
    @(negedge clk);
  endtask

  task automatic random_item();
    logic [7:0] lo, hi;
    if ($urandom_range(0, 99) < 12) begin
      lo = 8'($urandom_range(0, 255));
      hi = ($urandom_range(0, 3) != 0) ? 8'(lo + $urandom_range(0, 255 - lo))
                                       : 8'($urandom_range(0, 255));
      send_item(1'b1, 8'($urandom), 4'($urandom), lo, hi, 8'($urandom),
                $urandom_range(0, 6) != 0, 1'b0, '{default: '0});
    end else begin
      case ($urandom_range(0, 9))
        0: lo = 8'd0;
        1: lo = 8'd255;
        2, 3: lo = 8'($urandom_range(100, 160));
        default: lo = 8'($urandom);
      endcase
      send_item(1'b0, lo, 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                1'($urandom), 1'b0, '{default: '0});
    end
  endtask

  // Lets the pipeline empty, then covers a tile that may still be in flight.
  task automatic drain();
    in_tvalid = 1'b0;
    while (tile_expect.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_FRAME_WIDTH:  begin geo_fw = val[12:0]; restart_geometry(); end
      CFG_FRAME_HEIGHT: begin geo_fh = val[12:0]; restart_geometry(); end
      CFG_TILE_WIDTH:   begin geo_tw = val[6:0];  restart_geometry(); end
      CFG_TILE_HEIGHT:  begin geo_th = val[6:0];  restart_geometry(); end
      CFG_RANDOM_SEED:  sel_lfsr = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_geometry(input logic [15:0] fw, input logic [15:0] fh,
                              input logic [15:0] tw, input logic [15:0] th,
                              input logic [15:0] seed);
    write_reg(CFG_FRAME_WIDTH, fw);
    write_reg(CFG_FRAME_HEIGHT, fh);
    write_reg(CFG_TILE_WIDTH, tw);
    write_reg(CFG_TILE_HEIGHT, th);
    write_reg(CFG_RANDOM_SEED, seed);
  endtask

  // Receiver: alternating stall and ready stretches of random length.
  bit rx_stall = 1'b1;
  int rx_left = 0;
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_stall = !rx_stall;
      rx_left = rx_stall ? $urandom_range(1, 12) : $urandom_range(1, 60);
    end
    rx_left--;
    out_tready <= !rx_stall;
  end

  always @(posedge clk) begin
    tile_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (tile_expect.size() == 0) begin
        errors++;
        $display("%0t: unexpected tile result, tdata=%h tuser=%b tlast=%b",
                 $time, out_tdata, out_tuser, out_tlast);
      end else begin
        want = tile_expect.pop_front();
        if (out_tdata[7:0] !== want.glyph || out_tuser[0] !== want.fb ||
            out_tdata[15:8] !== want.avg || out_tdata[27:16] !== want.col ||
            out_tdata[39:28] !== want.row || out_tlast !== want.eol ||
            out_tuser[1] !== want.eof) begin
          errors++;
          $display("%0t: tile mismatch, expected glyph=%h fb=%b avg=%0d col=%0d row=%0d eol=%b eof=%b",
                   $time, want.glyph, want.fb, want.avg, want.col, want.row, want.eol, want.eof);
          $display("%0t:                actual glyph=%h fb=%b avg=%0d col=%0d row=%0d eol=%b eof=%b",
                   $time, out_tdata[7:0], out_tuser[0], out_tdata[15:8], out_tdata[27:16],
                   out_tdata[39:28], out_tlast, out_tuser[1]);
        end
      end
    end
  end

  // Watchdog: counts cycles without any transfer on any channel.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 3000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  dir_row_t dir_rows [14];

  initial begin
    tile_res_t typed_res;
    int phase_items;
    geo_fw = 13'd640;
    geo_fh = 13'd480;
    geo_tw = 7'd5;
    geo_th = 7'd5;
    sel_lfsr = SEED_RESET;
    restart_geometry();
    for (int i = 0; i < TABLE_ENTRIES; i++) slot_on[i] = 1'b0;

    // On a one-pixel frame every pixel is a whole tile at the origin.
    dir_rows = '{
      '{0, 8'd0,   0, 0, 0, 0, 0, 1, 8'h00, 1, 8'd0},
      '{0, 8'd255, 0, 0, 0, 0, 0, 1, 8'h00, 1, 8'd255},
      '{1, 8'h55,  4'd0,  8'd0,   8'd255, 8'h41, 1, 0, 0, 0, 0},
      '{1, 8'h00,  4'd15, 8'd200, 8'd100, 8'h42, 1, 0, 0, 0, 0},
      '{1, 8'h00,  4'd7,  8'd128, 8'd128, 8'hFF, 1, 0, 0, 0, 0},
      '{1, 8'h00,  4'd3,  8'd0,   8'd50,  8'h2E, 0, 0, 0, 0, 0},
      '{0, 8'd128, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 8'd150, 0, 0, 0, 0, 0, 1, 8'h41, 0, 8'd150},
      '{0, 8'd0,   0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{1, 8'hAA,  4'd0,  8'd0,   8'd255, 8'h41, 0, 0, 0, 0, 0},
      '{0, 8'd150, 0, 0, 0, 0, 0, 1, 8'h00, 1, 8'd150},
      '{0, 8'd128, 0, 0, 0, 0, 0, 1, 8'hFF, 0, 8'd128},
      '{1, 8'h00,  4'd15, 8'd0,   8'd255, 8'h80, 1, 0, 0, 0, 0},
      '{0, 8'd255, 0, 0, 0, 0, 0, 0, 0, 0, 0}
    };

    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    set_geometry(16'd1, 16'd1, 16'd1, 16'd1, 16'hFFFF);
    foreach (dir_rows[i]) begin
      typed_res = '{glyph: dir_rows[i].e_gl, fb: dir_rows[i].e_fb, avg: dir_rows[i].e_avg,
                    col: 12'd0, row: 12'd0, eol: 1'b1, eof: 1'b1};
      send_item(dir_rows[i].tbl, dir_rows[i].pix, dir_rows[i].idx, dir_rows[i].lo,
                dir_rows[i].hi, dir_rows[i].gl, dir_rows[i].v, dir_rows[i].typed, typed_res);
    end
    drain();

    // Zero geometry counts as one, and a zero seed freezes the selection.
    set_geometry(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    repeat (6) random_item();
    drain();

    // Widest frame with clamped sizes: the first 16 full-width tiles of the row.
    set_geometry(16'h1FFF, 16'd1, 16'h7F, 16'd64, 16'd1);
    repeat (1024) send_item(1'b0, 8'($urandom), 4'($urandom), 8'($urandom), 8'($urandom),
                            8'($urandom), 1'($urandom), 1'b0, '{default: '0});
    drain();

    while (items_sent < 1750) begin
      set_geometry($urandom_range(0, 7) == 0 ? 16'd4096 : 16'($urandom_range(1, 40)),
                   16'($urandom_range(1, 20)),
                   $urandom_range(0, 9) == 0 ? 16'd64 : 16'($urandom_range(1, 8)),
                   $urandom_range(0, 9) == 0 ? 16'd64 : 16'($urandom_range(1, 8)),
                   $urandom_range(0, 7) == 0 ? 16'd0 : 16'($urandom_range(1, 65535)));
      phase_items = $urandom_range(100, 250);
      for (int n = 0; n < phase_items; n++) begin
        if (n == phase_items / 2 && $urandom_range(0, 1) == 0) drain();
        random_item();
      end
      drain();
    end

    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
